@@ rtl/skdf_pkg.sv @@
// shared constants, register indexes and the exp2 factor table of the delay filter
package skdf_pkg;

   localparam int ADDR_W = 5;
   localparam int MUL_W  = 34;

   localparam logic [2:0] REG_COEF  = 3'd0;
   localparam logic [2:0] REG_QVAR  = 3'd1;
   localparam logic [2:0] REG_RMIN  = 3'd2;
   localparam logic [2:0] REG_PINIT = 3'd3;
   localparam logic [2:0] REG_RINIT = 3'd4;

   localparam logic [15:0] COEF_RST  = 16'd655;
   localparam logic [15:0] QVAR_RST  = 16'd66;
   localparam logic [31:0] RMIN_RST  = 32'd65536;
   localparam logic [31:0] PINIT_RST = 32'd6554;
   localparam logic [31:0] RINIT_RST = 32'd65536;

   localparam logic [30:0] ONE30 = 31'h4000_0000;

   typedef logic [15:0][31:0] exp_tab_type;

   // integer square root, elaboration use only
   function automatic logic [63:0] isqrt_c(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] x;
      r = 64'd0;
      b = 64'd1 << 62;
      x = v;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-2^-(i+1)) in q2.30, truncated square roots
   function automatic exp_tab_type exp_table();
      exp_tab_type t;
      logic [63:0] c;
      c = isqrt_c(64'd1 << 59);
      for (int i = 0; i < 16; i++) begin
         t[i] = c[31:0];
         c = isqrt_c(c << 30);
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = exp_table();

endpackage

@@ rtl/scalar_kalman_delay_filter.sv @@
// scalar kalman filter for inter-group delay variation, one shared multiplier and shift-subtract unit
//
// channel  dir  beat fields (low bit first)
// req      in   delay_sample[31:0] s, group_rate[47:32] u
// rsp      out  estimate[31:0] s, noise_variance[63:32] u
// csr      apb  five registers at byte address 4*i, pready always high
//
// one beat runs through the 32-step square root, 16 log2 squarings, a 32-step divide for the
// exponent, 16 exp2 products, three multiply passes for the noise variance and the 64-step gain
// divide (skipped when the gain denominator is zero), all on one multiplier and one
// shift-subtract unit.
// req_tready is high only in the idle state; a finished result sits in the output register
// and a new beat may be taken while it waits. a stalled result holds the sequencer at its last
// step. reset is synchronous and loads the register defaults and the filter state.
module scalar_kalman_delay_filter #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // delay_sample[31:0], group_rate[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // estimate[31:0], noise_variance[63:32]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [skdf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int MW   = skdf_pkg::MUL_W;
   localparam int PW   = 2 * MW;
   localparam int S2W  = PW - FRAC_BITS;      // rounded squared innovation
   localparam int ACCW = S2W + 18;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_SQRT  = 5'd1;
   localparam logic [4:0] ST_SQR   = 5'd2;
   localparam logic [4:0] ST_LOG   = 5'd3;
   localparam logic [4:0] ST_LPREP = 5'd4;
   localparam logic [4:0] ST_UDIV  = 5'd5;
   localparam logic [4:0] ST_EXP   = 5'd6;
   localparam logic [4:0] ST_WQ    = 5'd7;
   localparam logic [4:0] ST_MR1   = 5'd8;
   localparam logic [4:0] ST_MR2   = 5'd9;
   localparam logic [4:0] ST_MR3   = 5'd10;
   localparam logic [4:0] ST_RFIN  = 5'd11;
   localparam logic [4:0] ST_GPREP = 5'd12;
   localparam logic [4:0] ST_GDIV  = 5'd13;
   localparam logic [4:0] ST_GCL   = 5'd14;
   localparam logic [4:0] ST_MP    = 5'd15;
   localparam logic [4:0] ST_ME    = 5'd16;

   localparam logic [6:0] LAST16 = 7'd15;
   localparam logic [6:0] LAST32 = 7'd31;
   localparam logic [6:0] LAST64 = 7'd63;

   // control and filter state
   logic [4:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic signed [31:0] est_ff, est_in;
   logic [31:0] pvar_ff, pvar_in;
   logic [31:0] nvar_ff, nvar_in;
   // configuration
   logic [15:0] coef_ff, coef_in;
   logic [15:0] qvar_ff, qvar_in;
   logic [31:0] rmin_ff, rmin_in;
   logic [31:0] pinit_ff, pinit_in;
   logic [31:0] rinit_ff, rinit_in;
   // per-beat working registers
   logic        neg_ff, neg_in;
   logic [32:0] mag_ff, mag_in;
   logic [15:0] rate_ff, rate_in;
   logic [S2W-1:0] s2_ff, s2_in;
   logic [31:0] y_ff, y_in;
   logic [4:0]  k_ff, k_in;
   logic [15:0] frac_ff, frac_in;
   logic [22:0] u_ff, u_in;
   logic [31:0] w_ff, w_in;
   logic [16:0] wq_ff, wq_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic [32:0] pp_ff, pp_in;
   logic [30:0] g_ff, g_in;
   // shared shift-subtract unit (square root and divide)
   logic [35:0] it_rem_ff, it_rem_in;
   logic [63:0] it_op_ff, it_op_in;
   logic [63:0] it_q_ff, it_q_in;
   logic [33:0] it_den_ff, it_den_in;

   logic [35:0] st_rem_sh;
   logic [35:0] st_sub;
   logic [36:0] st_diff;
   logic        st_ge;
   logic [35:0] st_rem;
   logic [63:0] st_op;
   logic [63:0] st_q;

   // shared multiplier
   logic [MW-1:0] mul_a;
   logic [MW-1:0] mul_b;
   logic [PW-1:0] prod;

   // datapath helpers
   logic        req_accept;
   logic        csr_write;
   logic signed [33:0] innov;
   logic [33:0] lim;
   logic [33:0] s_clip;
   logic [16:0] lg_a;
   logic [4:0]  lg_k;
   logic [20:0] lg_l;
   logic [15:0] rate1;
   logic [31:0] u_num;
   logic [31:0] sq;
   logic [6:0]  ip;
   logic [31:0] e_val;
   logic [16:0] wq_inv;
   logic [ACCW-1:0] r_round;
   logic [31:0] r_sat;
   logic [31:0] r_new;
   logic [33:0] g_den;
   logic [37:0] p_round;
   logic [33:0] m_val;
   logic signed [34:0] est_new;
   logic [31:0] est_sat;

   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;

   // one step of the shift-subtract unit: two bits per root step, one per quotient step
   always_comb begin
      if (state_ff == ST_SQRT) begin
         st_rem_sh = {it_rem_ff[33:0], it_op_ff[63:62]};
         st_sub    = {2'b00, it_q_ff[31:0], 2'b01};
         st_op     = {it_op_ff[61:0], 2'b00};
      end else begin
         st_rem_sh = {it_rem_ff[34:0], it_op_ff[63]};
         st_sub    = {2'b00, it_den_ff};
         st_op     = {it_op_ff[62:0], 1'b0};
      end
      st_diff = {1'b0, st_rem_sh} - {1'b0, st_sub};
      st_ge   = !st_diff[36];
      st_rem  = st_ge ? st_diff[35:0] : st_rem_sh;
      st_q    = {it_q_ff[62:0], st_ge};
   end

   // innovation and clip against three times the root of the noise variance
   assign innov  = 34'(signed'({{2{req_tdata[31]}}, req_tdata[31:0]}))
                 - 34'(signed'({{2{est_ff[31]}}, est_ff}));
   assign lim    = {2'b00, it_q_ff[31:0]} + {1'b0, it_q_ff[31:0], 1'b0};
   assign s_clip = ({1'b0, mag_ff} < lim) ? {1'b0, mag_ff} : lim;

   // log2 front end: leading one of 1 - chi
   assign lg_a = 17'd65536 - {1'b0, coef_ff};
   always_comb begin
      lg_k = 5'd0;
      for (int b = 1; b < 17; b++) begin
         if (lg_a[b]) lg_k = 5'(b);
      end
   end
   assign lg_l  = 21'(21'd1 << 20) - ({k_ff, 16'h0000} + {5'd0, frac_ff});
   assign rate1 = (rate_ff == 16'd0) ? 16'd1 : rate_ff;
   assign u_num = 32'(lg_l) * 32'd3 + 32'(rate1) * 32'd50;
   assign sq    = prod[61:30];

   assign ip     = u_ff[22:16];
   assign e_val  = (ip >= 7'd31) ? 32'd0 : (w_ff >> ip);
   assign wq_inv = 17'd65536 - wq_ff;

   assign r_round = (acc_ff + ACCW'(32768)) >> 16;
   assign r_sat   = (|r_round[ACCW-1:32]) ? 32'hFFFF_FFFF : r_round[31:0];
   assign r_new   = (r_sat < rmin_ff) ? rmin_ff : r_sat;
   assign g_den   = 34'(nvar_ff) + 34'(pp_ff);

   assign p_round = 38'((prod + PW'(1 << 29)) >> 30);
   assign m_val   = 34'((prod + PW'(1 << 29)) >> 30);
   assign est_new = neg_ff ? (35'(est_ff) - signed'({1'b0, m_val}))
                           : (35'(est_ff) + signed'({1'b0, m_val}));
   assign est_sat = (est_new > 35'sd2147483647) ? 32'h7FFF_FFFF
                  : (est_new < -35'sd2147483648) ? 32'h8000_0000
                  : est_new[31:0];

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_SQR: begin
            mul_a = s_clip;
            mul_b = s_clip;
         end
         ST_LOG: begin
            mul_a = MW'(y_ff);
            mul_b = MW'(y_ff);
         end
         ST_EXP: begin
            mul_a = MW'(w_ff);
            mul_b = MW'(skdf_pkg::EXP_TAB[cnt_ff[3:0]]);
         end
         ST_MR1: begin
            mul_a = MW'(wq_ff);
            mul_b = MW'(nvar_ff);
         end
         ST_MR2: begin
            mul_a = MW'(wq_inv);
            mul_b = s2_ff[MW-1:0];
         end
         ST_MR3: begin
            mul_a = MW'(wq_inv);
            mul_b = MW'(s2_ff[S2W-1:MW]);
         end
         ST_MP: begin
            mul_a = MW'(skdf_pkg::ONE30 - g_ff);
            mul_b = MW'(pp_ff);
         end
         ST_ME: begin
            mul_a = MW'(mag_ff);
            mul_b = MW'(g_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = PW'(mul_a) * PW'(mul_b);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      est_in       = est_ff;
      pvar_in      = pvar_ff;
      nvar_in      = nvar_ff;
      coef_in      = coef_ff;
      qvar_in      = qvar_ff;
      rmin_in      = rmin_ff;
      pinit_in     = pinit_ff;
      rinit_in     = rinit_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rate_in      = rate_ff;
      s2_in        = s2_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      u_in         = u_ff;
      w_in         = w_ff;
      wq_in        = wq_ff;
      acc_in       = acc_ff;
      pp_in        = pp_ff;
      g_in         = g_ff;
      it_rem_in    = it_rem_ff;
      it_op_in     = it_op_ff;
      it_q_in      = it_q_ff;
      it_den_in    = it_den_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               neg_in    = innov[33];
               mag_in    = innov[33] ? 33'(-innov) : innov[32:0];
               rate_in   = req_tdata[47:32];
               it_op_in  = 64'(nvar_ff) << FRAC_BITS;
               it_rem_in = '0;
               it_q_in   = '0;
               cnt_in    = '0;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            it_rem_in = st_rem;
            it_op_in  = st_op;
            it_q_in   = st_q;
            cnt_in    = cnt_ff + 7'd1;
            if (cnt_ff == LAST32) state_in = ST_SQR;
         end
         ST_SQR: begin
            // rounded square of the clipped innovation, and normalize 1 - chi
            s2_in    = S2W'((prod + PW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            k_in     = lg_k;
            y_in     = 32'(lg_a) << (5'd30 - lg_k);
            frac_in  = '0;
            cnt_in   = '0;
            state_in = ST_LOG;
         end
         ST_LOG: begin
            if (sq[31]) begin
               y_in    = {1'b0, sq[31:1]};
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               y_in    = sq;
               frac_in = {frac_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == LAST16) state_in = ST_LPREP;
         end
         ST_LPREP: begin
            // exponent = round(3 * |log2| / (100 * rate))
            it_op_in  = {u_num, 32'h0000_0000};
            it_den_in = 34'(rate1) * 34'd100;
            it_rem_in = '0;
            it_q_in   = '0;
            cnt_in    = '0;
            state_in  = ST_UDIV;
         end
         ST_UDIV: begin
            it_rem_in = st_rem;
            it_op_in  = st_op;
            it_q_in   = st_q;
            cnt_in    = cnt_ff + 7'd1;
            if (cnt_ff == LAST32) begin
               u_in     = st_q[22:0];
               w_in     = 32'(skdf_pkg::ONE30);
               cnt_in   = '0;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (u_ff[4'd15 - cnt_ff[3:0]]) w_in = prod[61:30];
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == LAST16) state_in = ST_WQ;
         end
         ST_WQ: begin
            wq_in    = 17'((33'(e_val) + 33'(1 << 13)) >> 14);
            state_in = ST_MR1;
         end
         ST_MR1: begin
            acc_in   = ACCW'(prod);
            state_in = ST_MR2;
         end
         ST_MR2: begin
            acc_in   = acc_ff + ACCW'(prod);
            state_in = ST_MR3;
         end
         ST_MR3: begin
            acc_in   = acc_ff + (ACCW'(prod) << MW);
            state_in = ST_RFIN;
         end
         ST_RFIN: begin
            nvar_in  = r_new;
            pp_in    = 33'(pvar_ff) + 33'(qvar_ff);
            state_in = ST_GPREP;
         end
         ST_GPREP: begin
            if (g_den == 34'd0) begin
               g_in     = '0;
               state_in = ST_MP;
            end else begin
               it_op_in  = (64'(pp_ff) << 30) + 64'(g_den >> 1);
               it_den_in = g_den;
               it_rem_in = '0;
               it_q_in   = '0;
               cnt_in    = '0;
               state_in  = ST_GDIV;
            end
         end
         ST_GDIV: begin
            it_rem_in = st_rem;
            it_op_in  = st_op;
            it_q_in   = st_q;
            cnt_in    = cnt_ff + 7'd1;
            if (cnt_ff == LAST64) state_in = ST_GCL;
         end
         ST_GCL: begin
            g_in     = (it_q_ff > 64'(skdf_pkg::ONE30)) ? skdf_pkg::ONE30 : it_q_ff[30:0];
            state_in = ST_MP;
         end
         ST_MP: begin
            pvar_in  = (|p_round[37:32]) ? 32'hFFFF_FFFF : p_round[31:0];
            state_in = ST_ME;
         end
         ST_ME: begin
            // hold here while the previous result is still waiting
            if (!rsp_valid_ff || rsp_tready) begin
               est_in       = signed'(est_sat);
               rsp_data_in  = {nvar_ff, est_sat};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         unique case (csr_paddr[4:2])
            skdf_pkg::REG_COEF:  coef_in = csr_pwdata[15:0];
            skdf_pkg::REG_QVAR:  qvar_in = csr_pwdata[15:0];
            skdf_pkg::REG_RMIN:  rmin_in = csr_pwdata;
            skdf_pkg::REG_PINIT: begin
               pinit_in = csr_pwdata;
               pvar_in  = csr_pwdata;
            end
            skdf_pkg::REG_RINIT: begin
               rinit_in = csr_pwdata;
               nvar_in  = csr_pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[4:2])
         skdf_pkg::REG_COEF:  csr_prdata = 32'(coef_ff);
         skdf_pkg::REG_QVAR:  csr_prdata = 32'(qvar_ff);
         skdf_pkg::REG_RMIN:  csr_prdata = rmin_ff;
         skdf_pkg::REG_PINIT: csr_prdata = pinit_ff;
         skdf_pkg::REG_RINIT: csr_prdata = rinit_ff;
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         est_ff       <= '0;
         pvar_ff      <= skdf_pkg::PINIT_RST;
         nvar_ff      <= skdf_pkg::RINIT_RST;
         coef_ff      <= skdf_pkg::COEF_RST;
         qvar_ff      <= skdf_pkg::QVAR_RST;
         rmin_ff      <= skdf_pkg::RMIN_RST;
         pinit_ff     <= skdf_pkg::PINIT_RST;
         rinit_ff     <= skdf_pkg::RINIT_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff       <= est_in;
         pvar_ff      <= pvar_in;
         nvar_ff      <= nvar_in;
         coef_ff      <= coef_in;
         qvar_ff      <= qvar_in;
         rmin_ff      <= rmin_in;
         pinit_ff     <= pinit_in;
         rinit_ff     <= rinit_in;
      end
   end

   // payload and working registers, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rate_ff     <= rate_in;
      s2_ff       <= s2_in;
      y_ff        <= y_in;
      k_ff        <= k_in;
      frac_ff     <= frac_in;
      u_ff        <= u_in;
      w_ff        <= w_in;
      wq_ff       <= wq_in;
      acc_ff      <= acc_in;
      pp_ff       <= pp_in;
      g_ff        <= g_in;
      it_rem_ff   <= it_rem_in;
      it_op_ff    <= it_op_in;
      it_q_ff     <= it_q_in;
      it_den_ff   <= it_den_in;
   end

   // an accepted beat always starts with the root step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SQRT))
      else $error("accepted beat did not start the root step");

   // the gain never exceeds one when the error variance is updated
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MP) |-> (g_ff <= skdf_pkg::ONE30))
      else $error("gain above one");

   // a result appears only from the final step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ME))
      else $error("result raised outside the final step");

endmodule

@@ verif/skdf_checker.sv @@
// checker for the delay filter: tracks register writes, predicts each result beat and compares
module skdf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // delay_sample[31:0], group_rate[47:32]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // estimate[31:0], noise_variance[63:32]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [skdf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          errors,
   output int          pending,
   output int          results_seen
);

   localparam int FB = 16;
   localparam logic [63:0] Q30 = 64'd1 << 30;

   typedef struct packed {
      logic [31:0] noise_var;
      logic [31:0] estimate;
   } filter_out_type;

   filter_out_type filter_q[$];

   logic [63:0] chi, qvar, rmin, pinit, rinit;
   logic [63:0] pvar_st, rvar_st;
   longint      est_st;

   function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // |log2(a/65536)| in q.16 by repeated squaring
   function automatic logic [63:0] log2_mag_q16(input logic [63:0] a);
      int k;
      logic [63:0] y;
      logic [63:0] frac;
      k = 0;
      frac = 0;
      while (k < 16 && (a >> (k + 1)) != 0) k++;
      y = a << (30 - k);
      for (int i = 15; i >= 0; i--) begin
         y = (y * y) >> 30;
         if (y >= (Q30 << 1)) begin
            y = y >> 1;
            frac = frac | (64'd1 << i);
         end
      end
      return (64'd16 << 16) - ((64'(k) << 16) + frac);
   endfunction

   // 2^-u, u in q.16, result q.30
   function automatic logic [63:0] pow2_neg_q30(input logic [63:0] u);
      logic [63:0] w;
      logic [63:0] c;
      w = Q30;
      c = sqrt_floor(64'd1 << 59);
      for (int i = 0; i < 16; i++) begin
         if (u[15-i]) w = (w * c) >> 30;
         c = sqrt_floor(c << 30);
      end
      if ((u >> 16) >= 31) return 0;
      return w >> (u >> 16);
   endfunction

   task automatic advance_filter(input logic [31:0] sample, input logic [15:0] rate_in);
      longint smp, innov, est;
      logic neg;
      logic [63:0] mag, r, lim, s, s2, rate, d, u, w, pp, den, g, p, m;
      filter_out_type o;
      smp = longint'($signed(sample));
      innov = smp - est_st;
      neg = innov < 0;
      mag = neg ? 64'(-innov) : 64'(innov);
      r = rvar_st;
      lim = 3 * sqrt_floor(r << FB);
      s = mag < lim ? mag : lim;
      s2 = (s * s + ((64'd1 << FB) >> 1)) >> FB;
      rate = (rate_in == 0) ? 64'd1 : 64'(rate_in);
      d = 100 * rate;
      u = (log2_mag_q16(64'd65536 - chi) * 3 + d / 2) / d;
      w = (pow2_neg_q30(u) + (64'd1 << 13)) >> 14;
      r = (w * r + (64'd65536 - w) * s2 + 64'd32768) >> 16;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      if (r < rmin) r = rmin;
      rvar_st = r;
      pp = pvar_st + qvar;
      den = r + pp;
      g = (den != 0) ? ((pp << 30) + den / 2) / den : 64'd0;
      if (g > Q30) g = Q30;
      p = ((Q30 - g) * pp + (Q30 >> 1)) >> 30;
      pvar_st = (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
      m = (mag * g + (Q30 >> 1)) >> 30;
      est = neg ? est_st - longint'(m) : est_st + longint'(m);
      if (est > 64'sd2147483647) est = 64'sd2147483647;
      if (est < -64'sd2147483648) est = -64'sd2147483648;
      est_st = est;
      o.estimate = est[31:0];
      o.noise_var = r[31:0];
      filter_q.push_back(o);
   endtask

   initial begin
      errors = 0;
      pending = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      filter_out_type want, got;
      if (reset) begin
         chi = skdf_pkg::COEF_RST;
         qvar = skdf_pkg::QVAR_RST;
         rmin = skdf_pkg::RMIN_RST;
         pinit = skdf_pkg::PINIT_RST;
         rinit = skdf_pkg::RINIT_RST;
         est_st = 0;
         pvar_st = skdf_pkg::PINIT_RST;
         rvar_st = skdf_pkg::RINIT_RST;
         filter_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[skdf_pkg::ADDR_W-1:2])
               skdf_pkg::REG_COEF:  chi  = csr_pwdata[15:0];
               skdf_pkg::REG_QVAR:  qvar = csr_pwdata[15:0];
               skdf_pkg::REG_RMIN:  rmin = csr_pwdata;
               skdf_pkg::REG_PINIT: begin
                  pinit = csr_pwdata;
                  pvar_st = pinit;
               end
               skdf_pkg::REG_RINIT: begin
                  rinit = csr_pwdata;
                  rvar_st = rinit;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) advance_filter(req_tdata[31:0], req_tdata[47:32]);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen++;
            if (filter_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result beat %h", rsp_tdata);
            end else begin
               want = filter_q.pop_front();
               if (got.estimate !== want.estimate || got.noise_var !== want.noise_var) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: estimate exp %h got %h, noise_var exp %h got %h",
                              want.estimate, got.estimate, want.noise_var, got.noise_var);
               end
            end
         end
      end
      pending = filter_q.size();
   end
endmodule

@@ verif/tb_top.sv @@
// top of the delay filter testbench: clock, reset, stimulus, flow control and verdict
module tb_top;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // delay_sample[31:0], group_rate[47:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;        // estimate[31:0], noise_variance[63:32]
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [skdf_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic        csr_pready;

   int errors, pending, results_seen;
   int send_idle, recv_idle;   // idle chance in percent per cycle
   int beats_sent, settings_used;
   int cycles = 0;

   scalar_kalman_delay_filter DUT (.*);

   skdf_checker checker_i (.*);

   initial forever #2 clock = ~clock;

   // hard stop if the design hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stall, redrawn every cycle
   always @(negedge clock) rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);

   // one apb write: setup cycle then access cycle
   task automatic csr_write(input int idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = skdf_pkg::ADDR_W'(idx * 4);
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   // one input beat; ready only moves at rising edges, so it is stable at the falling edge
   task automatic send_delay(input logic [31:0] sample, input logic [15:0] rate);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {rate, sample};
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      beats_sent++;
   endtask

   // let the filter drain before touching registers
   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic load_settings(input logic [15:0] coef, input logic [15:0] q,
                                input logic [31:0] rfloor, input logic [31:0] p0,
                                input logic [31:0] r0);
      csr_write(skdf_pkg::REG_COEF, coef);
      csr_write(skdf_pkg::REG_QVAR, q);
      csr_write(skdf_pkg::REG_RMIN, rfloor);
      csr_write(skdf_pkg::REG_PINIT, p0);
      csr_write(skdf_pkg::REG_RINIT, r0);
      settings_used++;
   endtask

   function automatic logic [15:0] pick_rate();
      case ($urandom_range(3))
         0: return 16'($urandom_range(65535));
         1: return 16'($urandom_range(3));
         default: return 16'($urandom_range(1, 120));
      endcase
   endfunction

   // mostly near zero, sometimes wild
   function automatic logic [31:0] pick_sample();
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000 << 16)) - (1000 << 16));
         default: return 32'($signed($urandom_range(200 << 16)) - (100 << 16));
      endcase
   endfunction

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) send_delay(pick_sample(), pick_rate());
      drain();
   endtask

   initial begin
      beats_sent = 0;
      settings_used = 1;
      send_idle = 18;
      recv_idle = 61;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: defaults, field extremes, zero and full rate
      send_delay(32'h7FFF_FFFF, 16'd0);
      send_delay(32'h8000_0000, 16'd65535);
      send_delay(32'h0000_0000, 16'd1);
      send_delay(32'h0001_0000, 16'd30);
      send_delay(32'hFFFF_0000, 16'd0);
      drain();
      // zero coefficient: weight exactly one
      load_settings(16'd0, 16'd0, 32'd0, 32'd6554, 32'd65536);
      send_delay(32'h0005_0000, 16'd10);
      send_delay(32'hFFF0_0000, 16'd65535);
      drain();
      // zero denominator: no noise, no error variance, no process noise
      load_settings(16'd655, 16'd0, 32'd0, 32'd0, 32'd0);
      send_delay(32'h7FFF_FFFF, 16'd1);
      send_delay(32'h8000_0000, 16'd0);
      drain();
      // saturation of both variances and the estimate
      load_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_delay(32'h7FFF_FFFF, 16'd1);
      send_delay(32'h7FFF_FFFF, 16'd0);
      send_delay(32'h8000_0000, 16'd65535);
      drain();
      load_settings(16'hFFFF, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
      send_delay(32'h8000_0000, 16'd1);
      send_delay(32'h7FFF_FFFF, 16'd1);
      drain();
      // write beyond the register file must be ignored
      csr_write(7, 32'hDEAD_BEEF);
      send_delay(32'h0000_8000, 16'd100);
      drain();

      // random phases, each under its own settings
      load_settings(16'd655, 16'd66, 32'd65536, 32'd6554, 32'd65536);
      random_phase(215);
      send_idle = 61;
      recv_idle = 18;
      load_settings(16'($urandom_range(1, 65535)), 16'($urandom),
                    32'($urandom_range(1 << 20)), $urandom, 32'($urandom_range(1 << 24)));
      random_phase(215);
      send_idle = 0;
      recv_idle = 0;
      load_settings(16'($urandom_range(1, 4000)), 16'($urandom_range(200)),
                    32'd4096, 32'($urandom_range(1 << 18)), $urandom);
      random_phase(205);

      $display("sent %0d delay beats and checked %0d results over %0d register settings",
               beats_sent, results_seen, settings_used);
      $display("flow control covered sender-heavy, receiver-heavy and stall-free mixes");
      if (errors == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
